// ===== design/icpne_pkg.sv =====
package icpne_pkg;

	localparam int COORD_W = 20;
	localparam int ERR_W = 21;
	localparam int SQ_W = 42;
	localparam int MOM_W = 40;
	localparam int CROSS_W = 41;
	localparam int RES_W = 42;
	localparam int DIST_W = 43;
	localparam int CFG_W = 41;
	localparam int SUM_W = 56;
	localparam int CNT_W = 17;
	localparam int IDX_W = 5;
	localparam int NUM_MOM = 9;
	localparam int NUM_RES = 6;

	localparam logic [CNT_W-1:0] MAX_PAIRS = 17'd65536;
	localparam logic [CFG_W-1:0] CFG_RESET = 41'd1048576;

	localparam int M_XX = 0;
	localparam int M_YY = 1;
	localparam int M_ZZ = 2;
	localparam int M_XY = 3;
	localparam int M_XZ = 4;
	localparam int M_YZ = 5;
	localparam int M_X = 6;
	localparam int M_Y = 7;
	localparam int M_Z = 8;

	typedef logic signed [SUM_W-1:0] sum_t;
	typedef sum_t [NUM_MOM-1:0] mom_vec_t;
	typedef sum_t [NUM_RES-1:0] res_vec_t;

	typedef enum logic [IDX_W-1:0] {
		ENT_A00, ENT_A01, ENT_A02, ENT_A03, ENT_A04, ENT_A05,
		ENT_A11, ENT_A12, ENT_A13, ENT_A14, ENT_A15,
		ENT_A22, ENT_A23, ENT_A24, ENT_A25,
		ENT_A33, ENT_A34, ENT_A35,
		ENT_A44, ENT_A45,
		ENT_A55,
		ENT_B0, ENT_B1, ENT_B2, ENT_B3, ENT_B4, ENT_B5,
		ENT_COUNT
	} emit_entry_t;

	// Products of one pair, registered after the multipliers.
	typedef struct packed {
		logic last;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic signed [ERR_W-1:0] e0;
		logic signed [ERR_W-1:0] e1;
		logic signed [ERR_W-1:0] e2;
		logic signed [SQ_W-1:0] ee0;
		logic signed [SQ_W-1:0] ee1;
		logic signed [SQ_W-1:0] ee2;
		logic signed [MOM_W-1:0] mxx;
		logic signed [MOM_W-1:0] myy;
		logic signed [MOM_W-1:0] mzz;
		logic signed [MOM_W-1:0] mxy;
		logic signed [MOM_W-1:0] mxz;
		logic signed [MOM_W-1:0] myz;
		logic signed [CROSS_W-1:0] z_e1;
		logic signed [CROSS_W-1:0] y_e2;
		logic signed [CROSS_W-1:0] z_e0;
		logic signed [CROSS_W-1:0] x_e2;
		logic signed [CROSS_W-1:0] y_e0;
		logic signed [CROSS_W-1:0] x_e1;
	} pair_prod_t;

	// Finished batch handed to the emitter.
	typedef struct packed {
		logic load;
		mom_vec_t mom;
		res_vec_t res;
		logic [CNT_W-1:0] count;
	} batch_t;

	function automatic sum_t sat_fix(input logic signed [SUM_W:0] s);
		sum_t r;
		if (s[SUM_W] != s[SUM_W-1]) begin
			r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			r = s[SUM_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/icpne_front.sv =====
module icpne_front
	import icpne_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_valid,
	input  logic signed [COORD_W-1:0] src_x,
	input  logic signed [COORD_W-1:0] src_y,
	input  logic signed [COORD_W-1:0] src_z,
	input  logic signed [COORD_W-1:0] tgt_x,
	input  logic signed [COORD_W-1:0] tgt_y,
	input  logic signed [COORD_W-1:0] tgt_z,
	input  logic                      last_pair,
	output logic                      valid_s2,
	output pair_prod_t                prod_s2
);

	logic valid_s1;
	logic last_s1;
	logic signed [COORD_W-1:0] sx_s1, sy_s1, sz_s1, tx_s1, ty_s1, tz_s1;
	logic signed [ERR_W-1:0] e0, e1, e2;
	pair_prod_t prod_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1 <= src_x;
			sy_s1 <= src_y;
			sz_s1 <= src_z;
			tx_s1 <= tgt_x;
			ty_s1 <= tgt_y;
			tz_s1 <= tgt_z;
			last_s1 <= last_pair;
			prod_s2 <= prod_d;
		end
	end

	always_comb begin
		e0 = ERR_W'(tx_s1) - ERR_W'(sx_s1);
		e1 = ERR_W'(ty_s1) - ERR_W'(sy_s1);
		e2 = ERR_W'(tz_s1) - ERR_W'(sz_s1);
		prod_d.last = last_s1;
		prod_d.x = sx_s1;
		prod_d.y = sy_s1;
		prod_d.z = sz_s1;
		prod_d.e0 = e0;
		prod_d.e1 = e1;
		prod_d.e2 = e2;
		prod_d.ee0 = e0 * e0;
		prod_d.ee1 = e1 * e1;
		prod_d.ee2 = e2 * e2;
		prod_d.mxx = sx_s1 * sx_s1;
		prod_d.myy = sy_s1 * sy_s1;
		prod_d.mzz = sz_s1 * sz_s1;
		prod_d.mxy = sx_s1 * sy_s1;
		prod_d.mxz = sx_s1 * sz_s1;
		prod_d.myz = sy_s1 * sz_s1;
		prod_d.z_e1 = sz_s1 * e1;
		prod_d.y_e2 = sy_s1 * e2;
		prod_d.z_e0 = sz_s1 * e0;
		prod_d.x_e2 = sx_s1 * e2;
		prod_d.y_e0 = sy_s1 * e0;
		prod_d.x_e1 = sx_s1 * e1;
	end

endmodule

// ===== design/icpne_accum.sv =====
module icpne_accum
	import icpne_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             adv,
	input  logic             valid_s2,
	input  pair_prod_t       prod_s2,
	output batch_t           batch
);

	logic [CFG_W-1:0] gate_q;
	mom_vec_t mom_q, mom_d;
	res_vec_t res_q, res_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [DIST_W-1:0] d2;
	logic take;
	logic step;
	mom_vec_t mom_term;
	res_vec_t res_term;

	always_comb begin
		d2 = DIST_W'(prod_s2.ee0) + DIST_W'(prod_s2.ee1) + DIST_W'(prod_s2.ee2);
		step = valid_s2 && adv;
		take = step && (d2 < DIST_W'(gate_q)) && (cnt_q < MAX_PAIRS);

		mom_term[M_XX] = SUM_W'(prod_s2.mxx);
		mom_term[M_YY] = SUM_W'(prod_s2.myy);
		mom_term[M_ZZ] = SUM_W'(prod_s2.mzz);
		mom_term[M_XY] = SUM_W'(prod_s2.mxy);
		mom_term[M_XZ] = SUM_W'(prod_s2.mxz);
		mom_term[M_YZ] = SUM_W'(prod_s2.myz);
		mom_term[M_X] = SUM_W'(prod_s2.x);
		mom_term[M_Y] = SUM_W'(prod_s2.y);
		mom_term[M_Z] = SUM_W'(prod_s2.z);

		res_term[0] = SUM_W'(RES_W'(prod_s2.y_e2) - RES_W'(prod_s2.z_e1));
		res_term[1] = SUM_W'(RES_W'(prod_s2.z_e0) - RES_W'(prod_s2.x_e2));
		res_term[2] = SUM_W'(RES_W'(prod_s2.x_e1) - RES_W'(prod_s2.y_e0));
		res_term[3] = SUM_W'(prod_s2.e0);
		res_term[4] = SUM_W'(prod_s2.e1);
		res_term[5] = SUM_W'(prod_s2.e2);

		for (int i = 0; i < NUM_MOM; i++) begin
			mom_d[i] = take ? sat_fix((SUM_W+1)'($signed(mom_q[i]))
				+ (SUM_W+1)'($signed(mom_term[i]))) : mom_q[i];
		end
		for (int i = 0; i < NUM_RES; i++) begin
			res_d[i] = take ? sat_fix((SUM_W+1)'($signed(res_q[i]))
				+ (SUM_W+1)'($signed(res_term[i]))) : res_q[i];
		end
		cnt_d = take ? cnt_q + 1'b1 : cnt_q;

		batch.load = step && prod_s2.last;
		batch.mom = mom_d;
		batch.res = res_d;
		batch.count = cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= CFG_RESET;
			mom_q <= '0;
			res_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				gate_q <= cfg_wdata;
			end
			if (batch.load) begin
				mom_q <= '0;
				res_q <= '0;
				cnt_q <= '0;
			end else begin
				mom_q <= mom_d;
				res_q <= res_d;
				cnt_q <= cnt_d;
			end
		end
	end

endmodule

// ===== design/icpne_emit.sv =====
module icpne_emit
	import icpne_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  batch_t           batch,
	output logic             emit_free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] entry_index,
	output logic signed [SUM_W-1:0] entry_value,
	output logic             last_entry
);

	logic busy_q;
	logic [IDX_W-1:0] pos_q;
	mom_vec_t mom_q;
	res_vec_t res_q;
	logic [CNT_W-1:0] cnt_q;
	logic is_last;
	sum_t n_val;

	function automatic sum_t neg(input sum_t a);
		return sat_fix((SUM_W+1)'(0) - (SUM_W+1)'(a));
	endfunction

	function automatic sum_t add2(input sum_t a, input sum_t b);
		return sat_fix((SUM_W+1)'(a) + (SUM_W+1)'(b));
	endfunction

	assign is_last = (emit_entry_t'(pos_q) == ENT_COUNT);
	assign emit_free = !busy_q || (out_ready && is_last);
	assign out_valid = busy_q;
	assign entry_index = pos_q;
	assign last_entry = is_last;
	assign n_val = SUM_W'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= '0;
		end else if (batch.load) begin
			busy_q <= 1'b1;
			pos_q <= '0;
		end else if (busy_q && out_ready) begin
			if (is_last) begin
				busy_q <= 1'b0;
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (batch.load) begin
			mom_q <= batch.mom;
			res_q <= batch.res;
			cnt_q <= batch.count;
		end
	end

	always_comb begin
		case (emit_entry_t'(pos_q))
			ENT_A00: entry_value = add2(mom_q[M_YY], mom_q[M_ZZ]);
			ENT_A01: entry_value = neg(mom_q[M_XY]);
			ENT_A02: entry_value = neg(mom_q[M_XZ]);
			ENT_A04: entry_value = neg(mom_q[M_Z]);
			ENT_A05: entry_value = mom_q[M_Y];
			ENT_A11: entry_value = add2(mom_q[M_XX], mom_q[M_ZZ]);
			ENT_A12: entry_value = neg(mom_q[M_YZ]);
			ENT_A13: entry_value = mom_q[M_Z];
			ENT_A15: entry_value = neg(mom_q[M_X]);
			ENT_A22: entry_value = add2(mom_q[M_XX], mom_q[M_YY]);
			ENT_A23: entry_value = neg(mom_q[M_Y]);
			ENT_A24: entry_value = mom_q[M_X];
			ENT_A33: entry_value = n_val;
			ENT_A44: entry_value = n_val;
			ENT_A55: entry_value = n_val;
			ENT_B0: entry_value = res_q[0];
			ENT_B1: entry_value = res_q[1];
			ENT_B2: entry_value = res_q[2];
			ENT_B3: entry_value = res_q[3];
			ENT_B4: entry_value = res_q[4];
			ENT_B5: entry_value = res_q[5];
			ENT_COUNT: entry_value = n_val;
			default: entry_value = '0;
		endcase
	end

endmodule

// ===== design/icp_normal_equation_accumulator_top.sv =====
// A last pair passes the input and product registers before its batch loads the emitter.
// Throughput: one pair per cycle through both registers while in_ready is high.
// A batch emits 28 entries, one per cycle while out_ready is high; a last pair waits in
// the product stage only while the previous batch still has entries to deliver.
// Reset clears the sums, the count and all valid flags, and sets the gate to 1.0 square meter.
module icp_normal_equation_accumulator_top
	import icpne_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      max_match_dist_sq_we,
	input  logic [CFG_W-1:0]          max_match_dist_sq,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] src_x,
	input  logic signed [COORD_W-1:0] src_y,
	input  logic signed [COORD_W-1:0] src_z,
	input  logic signed [COORD_W-1:0] tgt_x,
	input  logic signed [COORD_W-1:0] tgt_y,
	input  logic signed [COORD_W-1:0] tgt_z,
	input  logic                      last_pair,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [IDX_W-1:0]          entry_index,
	output logic signed [SUM_W-1:0]   entry_value,
	output logic                      last_entry
);

	logic adv;
	logic valid_s2;
	logic emit_free;
	pair_prod_t prod_s2;
	batch_t batch;

	assign adv = !(valid_s2 && prod_s2.last) || emit_free;
	assign in_ready = adv;

	icpne_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.src_x     (src_x),
		.src_y     (src_y),
		.src_z     (src_z),
		.tgt_x     (tgt_x),
		.tgt_y     (tgt_y),
		.tgt_z     (tgt_z),
		.last_pair (last_pair),
		.valid_s2  (valid_s2),
		.prod_s2   (prod_s2)
	);

	icpne_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (max_match_dist_sq_we),
		.cfg_wdata (max_match_dist_sq),
		.adv       (adv),
		.valid_s2  (valid_s2),
		.prod_s2   (prod_s2),
		.batch     (batch)
	);

	icpne_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.batch       (batch),
		.emit_free   (emit_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.last_entry  (last_entry)
	);

endmodule

// ===== design/icpne_checker.sv =====
module icpne_checker
	import icpne_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [IDX_W-1:0]        entry_index,
	input logic signed [SUM_W-1:0] entry_value,
	input logic                    last_entry
);

	// A stalled result keeps its index and value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_index) && $stable(entry_value))
		else $error("stalled result changed");

	// The final entry of a run always carries the count index.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_entry |-> emit_entry_t'(entry_index) == ENT_COUNT)
		else $error("last_entry on wrong index");

	// A run never pauses between entries once started.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_entry |=> out_valid)
		else $error("run of entries broke off");

	// Entries of a run come in order, one index after another.
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_entry |=>
			entry_index == $past(entry_index) + 1'b1)
		else $error("entry index skipped");

endmodule

bind icp_normal_equation_accumulator_top icpne_checker u_icpne_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.entry_index (entry_index),
	.entry_value (entry_value),
	.last_entry  (last_entry)
);
